>>> src/lwch_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwch_pkg: shared types and constants of the lattice walk histogram unit
// Field widths of the item channels and the request and response records
// of the axis cell divider.
// ----------------------------------------------------------------------------
package lwch_pkg;

  localparam int ACTION_W  = 2;
  localparam int POS_W     = 10;
  localparam int CELL_W    = 10;
  localparam int OUT_CNT_W = 16;
  localparam int LAT_W     = 11;  // lattice size register
  localparam int GRID_W    = 6;   // grid size register
  localparam int COORD_W   = 11;  // coordinate after a unit step
  localparam int AXC_W     = 5;   // coarse cell index on one axis
  localparam int NUM_W     = 16;  // scaled coordinate fed to the divider

  typedef enum logic [ACTION_W-1:0] {
    ACT_MOVE  = 2'd0,
    ACT_PLACE = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  typedef struct packed {
    logic                      start;
    logic signed [COORD_W-1:0] coord;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [AXC_W-1:0] axis_bin;
  } div_rsp_t;

endpackage

>>> src/lwch_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwch_in_if / lwch_out_if: item channels of the lattice walk histogram unit
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lwch_in_if import lwch_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [ACTION_W-1:0]     action;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic                    axis;
  logic                    positive;
  logic [CELL_W-1:0]       cell_index;

  modport source (output valid, action, pos_x, pos_y, axis, positive, cell_index,
                  input ready);
  modport sink   (input valid, action, pos_x, pos_y, axis, positive, cell_index,
                  output ready);
endinterface

interface lwch_out_if import lwch_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] new_x;
  logic signed [POS_W-1:0] new_y;
  logic                    moved;
  logic                    escaped;
  logic [CELL_W-1:0]       cell_res;
  logic [OUT_CNT_W-1:0]    count;

  modport source (output valid, new_x, new_y, moved, escaped, cell_res, count,
                  input ready);
  modport sink   (input valid, new_x, new_y, moved, escaped, cell_res, count,
                  output ready);
endinterface

>>> src/lwch_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwch_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lwch_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/lwch_axis_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwch_axis_div: coarse cell of one coordinate
// Computes min(floor((p + L/2) * G / L), G - 1) with the low end clamped to
// zero, by a compare-and-subtract divider that yields one quotient bit a cycle.
// ----------------------------------------------------------------------------
module lwch_axis_div import lwch_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [LAT_W-1:0]  l_eff,
  input  logic [LAT_W-2:0]  h_half,
  input  logic [GRID_W-1:0] g_eff,
  input  div_req_t          req,
  output div_rsp_t          rsp
);

  typedef enum logic {D_IDLE, D_STEP} dstate_t;

  dstate_t          state_r, state_nxt;
  logic             done_r, done_nxt;
  logic [AXC_W-1:0] bin_r, bin_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [NUM_W-1:0] dsh_r, dsh_nxt;
  logic [AXC_W-1:0] q_r, q_nxt;
  logic [2:0]       step_r, step_nxt;

  logic signed [COORD_W:0]    t_s;
  logic [LAT_W-1:0]           t_u;
  logic [LAT_W+GRID_W-1:0]    prod;
  logic                       ge;
  logic [AXC_W-1:0]           q_sh;
  logic [GRID_W-1:0]          g_last;

  assign t_s    = {req.coord[COORD_W-1], req.coord} + $signed({2'b00, h_half});
  assign t_u    = t_s[COORD_W] ? '0 : t_s[COORD_W-1:0];
  assign prod   = {{GRID_W{1'b0}}, t_u} * {{LAT_W{1'b0}}, g_eff};
  assign ge     = (num_r >= dsh_r);
  assign q_sh   = {q_r[AXC_W-2:0], ge};
  assign g_last = g_eff - 6'd1;

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    bin_nxt   = bin_r;
    num_nxt   = num_r;
    dsh_nxt   = dsh_r;
    q_nxt     = q_r;
    step_nxt  = step_r;
    unique case (state_r)
      D_IDLE: begin
        if (req.start) begin
          if (t_u >= l_eff) begin
            // At or beyond the upper edge: the cell clamps to the last one.
            bin_nxt  = g_last[AXC_W-1:0];
            done_nxt = 1'b1;
          end else begin
            // t < L keeps the quotient below G, so five bits suffice.
            num_nxt   = prod[NUM_W-1:0];
            dsh_nxt   = {1'b0, l_eff, 4'b0000};
            q_nxt     = '0;
            step_nxt  = 3'(AXC_W - 1);
            state_nxt = D_STEP;
          end
        end
      end
      D_STEP: begin
        if (ge) begin
          num_nxt = num_r - dsh_r;
        end
        dsh_nxt  = dsh_r >> 1;
        q_nxt    = q_sh;
        step_nxt = step_r - 3'd1;
        if (step_r == 3'd0) begin
          bin_nxt   = q_sh;
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    bin_r  <= bin_nxt;
    num_r  <= num_nxt;
    dsh_r  <= dsh_nxt;
    q_r    <= q_nxt;
    step_r <= step_nxt;
  end

  assign rsp = {done_r, bin_r};

endmodule

>>> src/lattice_walk_cell_histogram_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_walk_cell_histogram_unit: lattice random walk with cell occupancy
// Applies one unit step, placement or count read per item and keeps
// saturating per-cell occupancy counts of a coarse grid.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the count memory to zero, one entry a cycle,
// and takes no item meanwhile; configuration writes are taken throughout.
// Items are handled one at a time. Each coordinate that has to be mapped to
// a coarse cell goes through the shared divider: a start, five quotient bits
// and a response, or only a start and a response when the coordinate lies
// past the upper edge. A move maps three coordinates (old x, old y, stepped
// coordinate) when the step is taken and two otherwise, a place maps two, a
// read none. The count memory is read and written at the same address, so
// each count update is a read followed by a write, and a taken move updates
// two cells. A result waits in the output register while the next item is
// accepted.
// ----------------------------------------------------------------------------
module lattice_walk_cell_histogram_unit import lwch_pkg::*; #(
  parameter int MAX_CELLS   = 1024,
  parameter int MAX_LATTICE = 1024,
  parameter int COUNT_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [LAT_W-1:0]     cfg_wdata,
  lwch_in_if.sink              in_ch,
  lwch_out_if.source           out_ch
);

  localparam int ADDR_W    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int LMAX_EVEN = MAX_LATTICE - (MAX_LATTICE % 2);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_CELLS - 1);

  typedef enum logic [2:0] {
    CFG_LATTICE_SIZE = 3'd0,
    CFG_GRID_SIZE    = 3'd1,
    CFG_HOLE_ENABLE  = 3'd2,
    CFG_HOLE_SIDE    = 3'd3,
    CFG_HOLE_WIDTH   = 3'd4
  } cfg_idx_t;

  localparam logic [1:0] SIDE_NEG_X = 2'd0;
  localparam logic [1:0] SIDE_POS_Y = 2'd1;
  localparam logic [1:0] SIDE_POS_X = 2'd2;
  localparam logic [1:0] SIDE_NEG_Y = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV_START, S_DIV_WAIT, S_RD_A, S_WR_A, S_RD_B, S_WR_B, S_DONE
  } state_t;

  typedef enum logic [1:0] {SEL_X, SEL_Y, SEL_T} div_sel_t;
  typedef enum logic [1:0] {OP_KEEP, OP_DEC, OP_INC} mem_op_t;

  // Configuration registers.
  logic [LAT_W-1:0]  lat_size_r;
  logic [GRID_W-1:0] grid_size_r;
  logic              hole_en_r;
  logic [1:0]        hole_side_r;
  logic [LAT_W-1:0]  hole_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_size_r   <= 11'd100;
      grid_size_r  <= 6'd8;
      hole_en_r    <= 1'b0;
      hole_side_r  <= 2'd0;
      hole_width_r <= 11'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LATTICE_SIZE: lat_size_r   <= cfg_wdata;
        CFG_GRID_SIZE:    grid_size_r  <= cfg_wdata[GRID_W-1:0];
        CFG_HOLE_ENABLE:  hole_en_r    <= cfg_wdata[0];
        CFG_HOLE_SIDE:    hole_side_r  <= cfg_wdata[1:0];
        CFG_HOLE_WIDTH:   hole_width_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective lattice and grid sizes.
  logic [LAT_W-1:0]  l_even, l_eff;
  logic [LAT_W-2:0]  h_half;
  logic [GRID_W-1:0] g_eff;

  assign l_even = {lat_size_r[LAT_W-1:1], 1'b0};
  assign l_eff  = (l_even < 11'd2) ? 11'd2 :
                  (int'(l_even) > MAX_LATTICE) ? LAT_W'(LMAX_EVEN) : l_even;
  assign h_half = l_eff[LAT_W-1:1];
  assign g_eff  = (grid_size_r == 6'd0) ? 6'd1 :
                  (grid_size_r > 6'd32) ? 6'd32 : grid_size_r;

  // Control and item registers.
  state_t   state_r, state_nxt;
  div_sel_t sel_r, sel_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic     out_valid_r, out_valid_nxt;

  logic [ACTION_W-1:0]     action_r, action_nxt;
  logic signed [POS_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic                    axis_r, axis_nxt, pos_r, pos_nxt;
  logic [CELL_W-1:0]       cidx_r, cidx_nxt;
  logic [AXC_W-1:0]        cx_r, cx_nxt, cy_r, cy_nxt, cn_r, cn_nxt;
  logic [COUNT_BITS-1:0]   cnt_r, cnt_nxt;

  logic signed [POS_W-1:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic                    omoved_r, omoved_nxt, oesc_r, oesc_nxt;
  logic [CELL_W-1:0]       ocell_r, ocell_nxt;
  logic [OUT_CNT_W-1:0]    ocnt_r, ocnt_nxt;

  // Step decisions from the held item.
  logic                      is_move, is_place, is_read;
  logic signed [POS_W-1:0]   base, other;
  logic signed [COORD_W-1:0] base11, tgt, other11;
  logic signed [COORD_W:0]   tgt12, hs12;
  logic [COORD_W-1:0]        other_abs;
  logic                      in_range, at_wall, taken, escape;
  logic [1:0]                want_side;

  assign is_move  = (action_r == ACT_MOVE);
  assign is_place = (action_r == ACT_PLACE);
  assign is_read  = (action_r == ACT_READ);

  assign base    = axis_r ? y_r : x_r;
  assign other   = axis_r ? x_r : y_r;
  assign base11  = {base[POS_W-1], base};
  assign other11 = {other[POS_W-1], other};
  assign tgt     = pos_r ? (base11 + 11'sd1) : (base11 - 11'sd1);
  assign tgt12   = {tgt[COORD_W-1], tgt};
  assign hs12    = $signed({2'b00, h_half});
  assign in_range  = (tgt12 >= -hs12) && (tgt12 <= hs12 - 12'sd1);
  assign at_wall   = pos_r ? (tgt12 == hs12) : (tgt12 == -hs12 - 12'sd1);
  assign want_side = axis_r ? (pos_r ? SIDE_POS_Y : SIDE_NEG_Y)
                            : (pos_r ? SIDE_POS_X : SIDE_NEG_X);
  assign other_abs = other11[COORD_W-1] ? (11'd0 - other11) : other11;
  assign taken     = is_move && in_range;
  assign escape    = is_move && !in_range && hole_en_r && at_wall &&
                     (hole_side_r == want_side) &&
                     (other_abs <= {1'b0, hole_width_r[LAT_W-1:1]});

  // Cell indexes from the per-axis cells.
  logic [AXC_W-1:0]  ncx, ncy;
  logic [LAT_W-1:0]  old_prod, new_prod, old_sum, new_sum;
  logic [CELL_W-1:0] cell_old, cell_new;

  assign ncx      = axis_r ? cx_r : cn_r;
  assign ncy      = axis_r ? cn_r : cy_r;
  assign old_prod = {6'd0, cy_r} * {5'd0, g_eff};
  assign new_prod = {6'd0, ncy} * {5'd0, g_eff};
  assign old_sum  = old_prod + {6'd0, cx_r};
  assign new_sum  = new_prod + {6'd0, ncx};
  assign cell_old = old_sum[CELL_W-1:0];
  assign cell_new = new_sum[CELL_W-1:0];

  // Read-modify-write of the count memory: phase A on the item's own cell,
  // phase B on the destination cell of a taken move.
  logic              phase_b;
  logic [CELL_W-1:0] addr_a, cur_cell;
  mem_op_t           op_a, cur_op;
  logic              cur_ok;
  logic [ADDR_W-1:0] cur_addr;
  logic [COUNT_BITS-1:0] ram_rdata, cnt_mod;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;

  assign phase_b  = (state_r == S_RD_B) || (state_r == S_WR_B);
  assign addr_a   = is_read ? cidx_r : cell_old;
  assign op_a     = is_place ? OP_INC : ((taken || escape) ? OP_DEC : OP_KEEP);
  assign cur_cell = phase_b ? cell_new : addr_a;
  assign cur_op   = phase_b ? OP_INC : op_a;
  assign cur_ok   = (int'(cur_cell) < MAX_CELLS);
  assign cur_addr = ADDR_W'(cur_cell);

  always_comb begin
    case (cur_op)
      OP_DEC:  cnt_mod = (ram_rdata == '0) ? ram_rdata : ram_rdata - 1'b1;
      OP_INC:  cnt_mod = (&ram_rdata) ? ram_rdata : ram_rdata + 1'b1;
      default: cnt_mod = ram_rdata;
    endcase
  end

  logic write_phase;
  assign write_phase = (state_r == S_WR_A) || (state_r == S_WR_B);
  assign ram_we    = (state_r == S_CLEAR) ||
                     (write_phase && cur_ok && (cur_op != OP_KEEP));
  assign ram_waddr = (state_r == S_CLEAR) ? clr_addr_r : cur_addr;
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : cnt_mod;

  lwch_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (MAX_CELLS)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cur_addr),
    .rdata (ram_rdata)
  );

  // Shared axis divider.
  div_req_t div_req;
  div_rsp_t div_rsp;

  always_comb begin
    div_req.start = (state_r == S_DIV_START);
    case (sel_r)
      SEL_X:   div_req.coord = {x_r[POS_W-1], x_r};
      SEL_Y:   div_req.coord = {y_r[POS_W-1], y_r};
      default: div_req.coord = tgt;
    endcase
  end

  lwch_axis_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .l_eff  (l_eff),
    .h_half (h_half),
    .g_eff  (g_eff),
    .req    (div_req),
    .rsp    (div_rsp)
  );

  logic in_beat;
  assign in_beat = in_ch.valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    action_nxt    = action_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    axis_nxt      = axis_r;
    pos_nxt       = pos_r;
    cidx_nxt      = cidx_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cn_nxt        = cn_r;
    cnt_nxt       = cnt_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    omoved_nxt    = omoved_r;
    oesc_nxt      = oesc_r;
    ocell_nxt     = ocell_r;
    ocnt_nxt      = ocnt_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_beat) begin
          action_nxt = in_ch.action;
          x_nxt      = in_ch.pos_x;
          y_nxt      = in_ch.pos_y;
          axis_nxt   = in_ch.axis;
          pos_nxt    = in_ch.positive;
          cidx_nxt   = in_ch.cell_index;
          sel_nxt    = SEL_X;
          cnt_nxt    = '0;
          case (action_t'(in_ch.action)) inside
            ACT_MOVE, ACT_PLACE: state_nxt = S_DIV_START;
            ACT_READ:            state_nxt = S_RD_A;
            default:             state_nxt = S_DONE;
          endcase
        end
      end
      S_DIV_START: state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          case (sel_r)
            SEL_X: begin
              cx_nxt    = div_rsp.axis_bin;
              sel_nxt   = SEL_Y;
              state_nxt = S_DIV_START;
            end
            SEL_Y: begin
              cy_nxt = div_rsp.axis_bin;
              if (taken) begin
                sel_nxt   = SEL_T;
                state_nxt = S_DIV_START;
              end else begin
                state_nxt = S_RD_A;
              end
            end
            default: begin
              cn_nxt    = div_rsp.axis_bin;
              state_nxt = S_RD_A;
            end
          endcase
        end
      end
      S_RD_A: state_nxt = S_WR_A;
      S_WR_A: begin
        cnt_nxt   = cur_ok ? cnt_mod : '0;
        state_nxt = taken ? S_RD_B : S_DONE;
      end
      S_RD_B: state_nxt = S_WR_B;
      S_WR_B: begin
        cnt_nxt   = cur_ok ? cnt_mod : '0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // The result beat goes out once the output register is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          ox_nxt     = '0;
          oy_nxt     = '0;
          ocell_nxt  = '0;
          if (is_move || is_place) begin
            ox_nxt    = (taken && !axis_r) ? tgt[POS_W-1:0] : x_r;
            oy_nxt    = (taken && axis_r)  ? tgt[POS_W-1:0] : y_r;
            ocell_nxt = taken ? cell_new : cell_old;
          end else if (is_read) begin
            ocell_nxt = cidx_r;
          end
          omoved_nxt = taken;
          oesc_nxt   = escape;
          ocnt_nxt   = OUT_CNT_W'(cnt_r);
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sel_r       <= SEL_X;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    action_r <= action_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    axis_r   <= axis_nxt;
    pos_r    <= pos_nxt;
    cidx_r   <= cidx_nxt;
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    cn_r     <= cn_nxt;
    cnt_r    <= cnt_nxt;
    ox_r     <= ox_nxt;
    oy_r     <= oy_nxt;
    omoved_r <= omoved_nxt;
    oesc_r   <= oesc_nxt;
    ocell_r  <= ocell_nxt;
    ocnt_r   <= ocnt_nxt;
  end

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.new_x    = ox_r;
  assign out_ch.new_y    = oy_r;
  assign out_ch.moved    = omoved_r;
  assign out_ch.escaped  = oesc_r;
  assign out_ch.cell_res = ocell_r;
  assign out_ch.count    = ocnt_r;

endmodule
